@@ hw/rtl/alt_pkg.sv @@
// ----------------------------------------------------------------------------
// alt_pkg: shared types and constants for the assembly line tokenizer
// Token word layout, the per-byte token bundle and the token kind codes.
// ----------------------------------------------------------------------------
`default_nettype none

package alt_pkg;

    // Token kind codes
    localparam logic [2:0] K_IDENT = 3'd0;
    localparam logic [2:0] K_PUNCT = 3'd1;
    localparam logic [2:0] K_DEC   = 3'd2;
    localparam logic [2:0] K_REAL  = 3'd3;
    localparam logic [2:0] K_HEX   = 3'd4;
    localparam logic [2:0] K_LINE  = 3'd5;

    // One result word
    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] num;
        logic [63:0] frac;
        logic [7:0]  digits;
        logic [31:0] offset;
        logic [15:0] length;
    } t_token;

    // Everything one source byte produces: up to two flushed tokens, then a line token
    typedef struct packed {
        logic        a_vld;
        t_token      a;
        logic        b_vld;
        t_token      b;
        logic        l_vld;
        logic [31:0] l_off;
        logic        l_len1;
    } t_bundle;

endpackage

`default_nettype wire

@@ hw/rtl/alt_front.sv @@
// ----------------------------------------------------------------------------
// alt_front: byte scanner
// Classifies one source byte per cycle while i_take holds, updates the scan
// state and packs the tokens the byte completes into one bundle for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module alt_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_take,
    input  wire logic [7:0]       i_char_byte,
    input  wire logic             i_end_of_input,
    output logic                  o_wr,
    output alt_pkg::t_bundle      o_bundle
);
    import alt_pkg::*;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_FF  = 8'hFF;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_US  = 8'h5F;
    localparam logic [7:0] CH_DOT = 8'h2E;
    localparam logic [7:0] CH_X   = 8'h78;
    localparam logic [7:0] CH_0   = 8'h30;
    localparam logic [7:0] CH_9   = 8'h39;
    localparam logic [7:0] CH_A   = 8'h61;
    localparam logic [7:0] CH_F   = 8'h66;
    localparam logic [7:0] CH_Z   = 8'h7A;
    localparam logic [7:0] CH_UA  = 8'h41;
    localparam logic [7:0] CH_UZ  = 8'h5A;

    typedef enum logic [8:0] {
        M_IDLE  = 9'b000000001,
        M_IDENT = 9'b000000010,
        M_PUNCT = 9'b000000100,
        M_ZERO  = 9'b000001000,
        M_DEC   = 9'b000010000,
        M_HEX   = 9'b000100000,
        M_FRAC  = 9'b001000000,
        M_DEAD  = 9'b010000000,
        M_DONE  = 9'b100000000
    } t_mode;

    t_mode       r_mode, n_mode;
    logic [63:0] r_acc, n_acc;
    logic [63:0] r_frac, n_frac;
    logic [7:0]  r_fcnt, n_fcnt;
    logic [31:0] r_start, n_start;
    logic [15:0] r_rlen, n_rlen;
    logic [31:0] r_pos, n_pos;
    logic        r_ne, n_ne;

    logic        is_alpha, is_digit, is_punct, is_sep, is_us, is_hexd;
    logic [3:0]  dec_d, hex_d;
    logic [63:0] mul_src, mul10;
    logic [15:0] rlen_grow;
    logic [31:0] pos_inc;
    t_bundle     bun;

    // Mode holds a token that a flush would emit
    function automatic logic f_live(t_mode m);
        return (m == M_IDENT) || (m == M_PUNCT) || (m == M_ZERO) ||
               (m == M_DEC) || (m == M_HEX) || (m == M_FRAC);
    endfunction

    // Token word a flush would emit
    function automatic t_token f_tok(t_mode m, logic [63:0] acc, logic [63:0] frac,
                                     logic [7:0] fcnt, logic [31:0] start,
                                     logic [15:0] rlen);
        t_token t;
        t = '0;
        t.offset = start;
        t.length = rlen;
        unique case (m)
            M_IDENT: t.kind = K_IDENT;
            M_PUNCT: t.kind = K_PUNCT;
            M_ZERO, M_DEC: begin
                t.kind = K_DEC;
                t.num  = acc;
            end
            M_HEX: begin
                t.kind = K_HEX;
                t.num  = acc;
            end
            M_FRAC: begin
                t.kind   = K_REAL;
                t.num    = acc;
                t.frac   = frac;
                t.digits = fcnt;
            end
            default: t.kind = K_IDENT;
        endcase
        return t;
    endfunction

    // Byte classes
    assign is_digit = (i_char_byte >= CH_0) && (i_char_byte <= CH_9);
    assign is_alpha = ((i_char_byte >= CH_A) && (i_char_byte <= CH_Z)) ||
                      ((i_char_byte >= CH_UA) && (i_char_byte <= CH_UZ));
    assign is_us    = (i_char_byte == CH_US);
    assign is_sep   = (i_char_byte == CH_SP) || (i_char_byte == CH_TAB);
    assign is_hexd  = is_digit || ((i_char_byte >= CH_A) && (i_char_byte <= CH_F));
    assign is_punct = !is_us &&
                      (((i_char_byte >= 8'h21) && (i_char_byte <= 8'h2F)) ||
                       ((i_char_byte >= 8'h3A) && (i_char_byte <= 8'h40)) ||
                       ((i_char_byte >= 8'h5B) && (i_char_byte <= 8'h60)) ||
                       ((i_char_byte >= 8'h7B) && (i_char_byte <= 8'h7E)));

    // Digit values
    assign dec_d = i_char_byte[3:0];
    assign hex_d = is_digit ? i_char_byte[3:0] : 4'(i_char_byte[3:0] + 4'd9);

    // Shared times-ten accumulate (integer part or fraction)
    assign mul_src = (r_mode == M_FRAC) ? r_frac : r_acc;
    assign mul10   = (mul_src << 3) + (mul_src << 1) + {60'd0, dec_d};

    assign rlen_grow = (r_rlen == 16'hFFFF) ? r_rlen : 16'(r_rlen + 16'd1);
    assign pos_inc   = 32'(r_pos + 32'd1);

    // Next state and token bundle for the byte on the input
    always_comb begin
        n_mode  = r_mode;
        n_acc   = r_acc;
        n_frac  = r_frac;
        n_fcnt  = r_fcnt;
        n_start = r_start;
        n_rlen  = r_rlen;
        n_pos   = r_pos;
        n_ne    = r_ne;
        bun     = '0;
        if (r_mode != M_DONE) begin
            if ((i_char_byte == CH_NUL) || (i_char_byte == CH_FF)) begin
                bun.a_vld  = f_live(r_mode);
                bun.a      = f_tok(r_mode, r_acc, r_frac, r_fcnt, r_start, r_rlen);
                bun.l_vld  = (i_char_byte == CH_FF) || r_ne;
                bun.l_off  = r_pos;
                bun.l_len1 = 1'b0;
                n_mode     = M_DONE;
            end else if (i_char_byte == CH_LF) begin
                bun.a_vld  = f_live(r_mode);
                bun.a      = f_tok(r_mode, r_acc, r_frac, r_fcnt, r_start, r_rlen);
                bun.l_vld  = 1'b1;
                bun.l_off  = r_pos;
                bun.l_len1 = 1'b1;
                n_mode     = i_end_of_input ? M_DONE : M_IDLE;
                n_ne       = 1'b0;
                n_pos      = pos_inc;
                n_acc      = '0;
                n_frac     = '0;
                n_fcnt     = '0;
                n_rlen     = '0;
            end else begin
                n_ne  = 1'b1;
                n_pos = pos_inc;
                if (r_mode == M_DEAD) begin
                    n_mode = M_DEAD;
                end else if ((r_mode == M_IDENT) && (is_alpha || is_digit || is_us)) begin
                    n_rlen = rlen_grow;
                end else if ((r_mode == M_PUNCT) && is_punct) begin
                    n_rlen = rlen_grow;
                end else if ((r_mode == M_ZERO) && (i_char_byte == CH_X)) begin
                    n_mode = M_HEX;
                    n_rlen = rlen_grow;
                end else if (((r_mode == M_ZERO) || (r_mode == M_DEC)) && is_digit) begin
                    n_acc  = mul10;
                    n_mode = M_DEC;
                    n_rlen = rlen_grow;
                end else if (((r_mode == M_ZERO) || (r_mode == M_DEC)) &&
                             (i_char_byte == CH_DOT)) begin
                    n_mode = M_FRAC;
                    n_rlen = rlen_grow;
                end else if ((r_mode == M_HEX) && is_hexd) begin
                    n_acc  = {r_acc[59:0], hex_d};
                    n_rlen = rlen_grow;
                end else if ((r_mode == M_FRAC) && is_digit) begin
                    n_frac = mul10;
                    n_fcnt = (r_fcnt == 8'hFF) ? r_fcnt : 8'(r_fcnt + 8'd1);
                    n_rlen = rlen_grow;
                end else begin
                    // Token ends here; this byte may open the next one
                    bun.a_vld = f_live(r_mode);
                    bun.a     = f_tok(r_mode, r_acc, r_frac, r_fcnt, r_start, r_rlen);
                    n_acc     = '0;
                    n_frac    = '0;
                    n_fcnt    = '0;
                    n_rlen    = '0;
                    n_mode    = M_IDLE;
                    if (is_sep) begin
                        n_mode = M_IDLE;
                    end else if (is_alpha || is_us) begin
                        n_mode  = M_IDENT;
                        n_start = r_pos;
                        n_rlen  = 16'd1;
                    end else if (is_punct) begin
                        n_mode  = M_PUNCT;
                        n_start = r_pos;
                        n_rlen  = 16'd1;
                    end else if (i_char_byte == CH_0) begin
                        n_mode  = M_ZERO;
                        n_start = r_pos;
                        n_rlen  = 16'd1;
                    end else if (is_digit) begin
                        n_mode  = M_DEC;
                        n_start = r_pos;
                        n_rlen  = 16'd1;
                        n_acc   = {60'd0, dec_d};
                    end else begin
                        n_mode = M_DEAD;
                    end
                end
                // Last byte: flush what is pending and close the line
                if (i_end_of_input) begin
                    bun.b_vld  = f_live(n_mode);
                    bun.b      = f_tok(n_mode, n_acc, n_frac, n_fcnt, n_start, n_rlen);
                    bun.l_vld  = 1'b1;
                    bun.l_off  = pos_inc;
                    bun.l_len1 = 1'b0;
                    n_mode     = M_DONE;
                end
            end
        end
    end

    assign o_wr     = i_take && (bun.a_vld || bun.b_vld || bun.l_vld);
    assign o_bundle = bun;

    // Scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_acc   <= '0;
            r_frac  <= '0;
            r_fcnt  <= '0;
            r_start <= '0;
            r_rlen  <= '0;
            r_pos   <= '0;
            r_ne    <= 1'b0;
        end else if (i_take) begin
            r_mode  <= n_mode;
            r_acc   <= n_acc;
            r_frac  <= n_frac;
            r_fcnt  <= n_fcnt;
            r_start <= n_start;
            r_rlen  <= n_rlen;
            r_pos   <= n_pos;
            r_ne    <= n_ne;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/alt_fifo.sv @@
// ----------------------------------------------------------------------------
// alt_fifo: token bundle queue
// Small register queue between the scanner and the token serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module alt_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr,
    input  wire alt_pkg::t_bundle i_wdata,
    output logic                  o_full,
    input  wire logic             i_rd,
    output alt_pkg::t_bundle      o_rdata,
    output logic                  o_empty
);
    import alt_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_bundle         r_mem [DEPTH];
    logic [AW-1:0]   r_wptr, r_rptr;
    logic [CW-1:0]   r_cnt;
    logic            do_wr, do_rd;

    function automatic logic [AW-1:0] f_next(logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : AW'(p + 1'b1);
    endfunction

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_wr) begin
                r_wptr <= f_next(r_wptr);
            end
            if (do_rd) begin
                r_rptr <= f_next(r_rptr);
            end
            if (do_wr && !do_rd) begin
                r_cnt <= CW'(r_cnt + 1'b1);
            end else if (do_rd && !do_wr) begin
                r_cnt <= CW'(r_cnt - 1'b1);
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/alt_back.sv @@
// ----------------------------------------------------------------------------
// alt_back: token serializer
// Holds one bundle and hands out its tokens one word at a time, in order.
// ----------------------------------------------------------------------------
`default_nettype none

module alt_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_q_empty,
    input  wire alt_pkg::t_bundle i_q_data,
    output logic                  o_q_rd,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output alt_pkg::t_token       o_tok,
    output logic                  o_last
);
    import alt_pkg::*;

    t_bundle    r_bun;
    logic [2:0] r_mask, n_mask;     // {line, b, a} still to deliver
    logic [2:0] low, rest;
    logic       take, load;
    t_token     line_tok;

    assign low     = r_mask & (~r_mask + 3'd1);
    assign rest    = r_mask & ~low;
    assign o_empty = (r_mask == '0);
    assign take    = i_pop && !o_empty;
    assign load    = (o_empty || (take && (rest == '0))) && !i_q_empty;
    assign o_q_rd  = load;
    assign o_last  = (rest == '0);

    // Line token word
    always_comb begin
        line_tok        = '0;
        line_tok.kind   = K_LINE;
        line_tok.offset = r_bun.l_off;
        line_tok.length = {15'd0, r_bun.l_len1};
    end

    // Oldest pending word
    always_comb begin
        if (r_mask[0]) begin
            o_tok = r_bun.a;
        end else if (r_mask[1]) begin
            o_tok = r_bun.b;
        end else begin
            o_tok = line_tok;
        end
    end

    always_comb begin
        n_mask = r_mask;
        if (take) begin
            n_mask = rest;
        end
        if (load) begin
            n_mask = {i_q_data.l_vld, i_q_data.b_vld, i_q_data.a_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else begin
            r_mask <= n_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_bun <= i_q_data;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/assembly_line_tokenizer.sv @@
// ----------------------------------------------------------------------------
// assembly_line_tokenizer: streaming tokenizer for assembly source bytes
// Path: a token word is registered in the bundle queue, then in the serializer.
// Throughput: one source byte per cycle while the queue has room; one token word
// per cycle out, so bytes completing two or three words drain through the queue.
// Reset: synchronous active-low; scanner at line start, queue and output empty.
// ----------------------------------------------------------------------------
`default_nettype none

module assembly_line_tokenizer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_char_byte,
    input  wire logic        i_end_of_input,
    output logic             empty,
    input  wire logic        pop,
    output logic [2:0]       o_kind,
    output logic [63:0]      o_number_value,
    output logic [63:0]      o_fraction_value,
    output logic [7:0]       o_fraction_digits,
    output logic [31:0]      o_token_offset,
    output logic [15:0]      o_token_length,
    output logic             o_last_of_step
);
    import alt_pkg::*;

    logic    take, q_wr, q_rd, q_full, q_empty;
    t_bundle q_wdata, q_rdata;
    t_token  tok;

    // Input word is taken whenever the bundle queue has room
    assign full = q_full;
    assign take = push && !q_full;

    alt_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_take         (take),
        .i_char_byte    (i_char_byte),
        .i_end_of_input (i_end_of_input),
        .o_wr           (q_wr),
        .o_bundle       (q_wdata)
    );

    alt_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_wdata (q_wdata),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_rdata (q_rdata),
        .o_empty (q_empty)
    );

    alt_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (q_rdata),
        .o_q_rd    (q_rd),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_tok     (tok),
        .o_last    (o_last_of_step)
    );

    // Result word fields
    assign o_kind            = tok.kind;
    assign o_number_value    = tok.num;
    assign o_fraction_value  = tok.frac;
    assign o_fraction_digits = tok.digits;
    assign o_token_offset    = tok.offset;
    assign o_token_length    = tok.length;

endmodule

`default_nettype wire

@@ test/tb_assembly_line_tokenizer.sv @@
// ----------------------------------------------------------------------------
// tb_assembly_line_tokenizer: self-checking bench for the source tokenizer
// Feeds one continuous source stream (a short directed line, then random
// lines under several idle patterns and one long output hold), ends it with a
// random terminator plus a few bytes that must be ignored, and checks every
// token word against a cycle-free scanner model in the bench.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_assembly_line_tokenizer;
    timeunit 1ns;
    timeprecision 1ps;

    import alt_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_BYTES    = 40;

    // Special source bytes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_EOF   = 8'hFF;

    // Scanner states of the bench model
    typedef enum logic [3:0] {
        SC_IDLE, SC_IDENT, SC_PUNCT, SC_ZERO, SC_DEC, SC_HEX, SC_FRAC, SC_DEAD, SC_DONE
    } t_scan;

    // One token word as seen on the output side
    typedef struct packed {
        logic   last;
        t_token tok;
    } t_word;

    // ------------------------------------------------------------------------
    // Token scoreboard: scanner model plus queue of expected token words
    // ------------------------------------------------------------------------
    class token_scoreboard;
        t_scan       mode;
        logic [63:0] int_acc;
        logic [63:0] frac_acc;
        logic [7:0]  frac_cnt;
        logic [31:0] tok_start;
        logic [15:0] tok_len;
        logic [31:0] pos;
        bit          line_used;
        t_word       expected_q[$];
        int          errors;
        int          words_seen;
        int          kind_count[6];

        function new();
            mode      = SC_IDLE;
            int_acc   = '0;
            frac_acc  = '0;
            frac_cnt  = '0;
            tok_start = '0;
            tok_len   = '0;
            pos       = '0;
            line_used = 1'b0;
            errors    = 0;
            words_seen = 0;
            foreach (kind_count[k]) kind_count[k] = 0;
        endfunction

        static function bit is_alpha(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        endfunction

        static function bit is_digit(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        static function bit is_punct(logic [7:0] c);
            if (c == "_") return 1'b0;
            return (c >= 8'h21 && c <= 8'h2F) || (c >= 8'h3A && c <= 8'h40) ||
                   (c >= 8'h5B && c <= 8'h60) || (c >= 8'h7B && c <= 8'h7E);
        endfunction

        function void emit(logic [2:0] kind, logic [63:0] num, logic [63:0] frac,
                           logic [7:0] digits, logic [31:0] off, logic [15:0] len);
            t_word w;
            w.last       = 1'b0;
            w.tok.kind   = kind;
            w.tok.num    = num;
            w.tok.frac   = frac;
            w.tok.digits = digits;
            w.tok.offset = off;
            w.tok.length = len;
            expected_q.push_back(w);
        endfunction

        // Emit the token in progress, if any, and clear the accumulators
        function void flush_token();
            case (mode)
                SC_IDENT: emit(K_IDENT, '0, '0, '0, tok_start, tok_len);
                SC_PUNCT: emit(K_PUNCT, '0, '0, '0, tok_start, tok_len);
                SC_ZERO, SC_DEC: emit(K_DEC, int_acc, '0, '0, tok_start, tok_len);
                SC_HEX:   emit(K_HEX, int_acc, '0, '0, tok_start, tok_len);
                SC_FRAC:  emit(K_REAL, int_acc, frac_acc, frac_cnt, tok_start, tok_len);
                default: ;
            endcase
            if (mode != SC_IDLE && mode != SC_DEAD && mode != SC_DONE) mode = SC_IDLE;
            int_acc  = '0;
            frac_acc = '0;
            frac_cnt = '0;
            tok_len  = '0;
        endfunction

        function void grow();
            if (tok_len != 16'hFFFF) tok_len++;
        endfunction

        function void start_token(t_scan m, logic [63:0] value);
            mode      = m;
            tok_start = pos;
            tok_len   = 16'd1;
            int_acc   = value;
            frac_acc  = '0;
            frac_cnt  = '0;
        endfunction

        // Ordinary byte: extend the current token or close it and open another
        function void consume(logic [7:0] c);
            bit hexd;
            hexd = is_digit(c) || (c >= "a" && c <= "f");
            if (mode == SC_DEAD) return;
            if (mode == SC_IDENT && (is_alpha(c) || is_digit(c) || c == "_")) begin
                grow();
                return;
            end
            if (mode == SC_PUNCT && is_punct(c)) begin
                grow();
                return;
            end
            if (mode == SC_ZERO && c == "x") begin
                mode = SC_HEX;
                grow();
                return;
            end
            if ((mode == SC_ZERO || mode == SC_DEC) && is_digit(c)) begin
                int_acc = int_acc * 64'd10 + 64'(c - 8'h30);
                mode    = SC_DEC;
                grow();
                return;
            end
            if ((mode == SC_ZERO || mode == SC_DEC) && c == ".") begin
                mode = SC_FRAC;
                grow();
                return;
            end
            if (mode == SC_HEX && hexd) begin
                int_acc = (int_acc << 4) + 64'(is_digit(c) ? c - 8'h30 : c - 8'h57);
                grow();
                return;
            end
            if (mode == SC_FRAC && is_digit(c)) begin
                frac_acc = frac_acc * 64'd10 + 64'(c - 8'h30);
                if (frac_cnt != 8'hFF) frac_cnt++;
                grow();
                return;
            end

            flush_token();
            if (c == CH_SPACE || c == CH_TAB) return;
            if (is_alpha(c) || c == "_") start_token(SC_IDENT, '0);
            else if (is_punct(c)) start_token(SC_PUNCT, '0);
            else if (c == "0") start_token(SC_ZERO, '0);
            else if (is_digit(c)) start_token(SC_DEC, 64'(c - 8'h30));
            else mode = SC_DEAD;
        endfunction

        // Accepted source byte: queue the token words it completes
        function void note_byte(logic [7:0] c, logic eoi);
            int    first;
            t_word w;
            first = expected_q.size();
            if (mode == SC_DONE) return;
            if (c == CH_NUL) begin
                flush_token();
                if (line_used) emit(K_LINE, '0, '0, '0, pos, 16'd0);
                mode = SC_DONE;
            end else if (c == CH_EOF) begin
                flush_token();
                emit(K_LINE, '0, '0, '0, pos, 16'd0);
                mode = SC_DONE;
            end else if (c == CH_LF) begin
                flush_token();
                emit(K_LINE, '0, '0, '0, pos, 16'd1);
                mode      = eoi ? SC_DONE : SC_IDLE;
                line_used = 1'b0;
                pos++;
            end else begin
                line_used = 1'b1;
                consume(c);
                pos++;
                if (eoi) begin
                    flush_token();
                    emit(K_LINE, '0, '0, '0, pos, 16'd0);
                    mode = SC_DONE;
                end
            end
            if (expected_q.size() > first) begin
                w      = expected_q.pop_back();
                w.last = 1'b1;
                expected_q.push_back(w);
            end
        endfunction

        function void cmp_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        // Output word: compare with the oldest expected word
        function void check_word(t_word got);
            t_word want;
            if (expected_q.size() == 0) begin
                $error("token word with nothing expected: kind %0d offset %0d",
                       got.tok.kind, got.tok.offset);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            words_seen++;
            if (want.tok.kind < 6) kind_count[want.tok.kind]++;
            cmp_field("kind", 64'(want.tok.kind), 64'(got.tok.kind));
            cmp_field("number_value", want.tok.num, got.tok.num);
            cmp_field("fraction_value", want.tok.frac, got.tok.frac);
            cmp_field("fraction_digits", 64'(want.tok.digits), 64'(got.tok.digits));
            cmp_field("token_offset", 64'(want.tok.offset), 64'(got.tok.offset));
            cmp_field("token_length", 64'(want.tok.length), 64'(got.tok.length));
            cmp_field("last_of_step", 64'(want.last), 64'(got.last));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, stimulus signals and the block
    // ------------------------------------------------------------------------
    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        push           = 1'b0;
    logic        pop            = 1'b0;
    logic [7:0]  i_char_byte    = 8'h20;
    logic        i_end_of_input = 1'b0;
    logic        full;
    logic        empty;
    logic [2:0]  o_kind;
    logic [63:0] o_number_value;
    logic [63:0] o_fraction_value;
    logic [7:0]  o_fraction_digits;
    logic [31:0] o_token_offset;
    logic [15:0] o_token_length;
    logic        o_last_of_step;

    token_scoreboard sb;
    int  tx_idle_pct    = 0;
    int  rx_stall_pct   = 0;
    int  bytes_sent     = 0;
    int  quiet_cycles   = 0;
    int  hold_left      = 0;
    bit  pressure_armed = 1'b0;
    bit  pressure_taken = 1'b0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    assembly_line_tokenizer dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .full              (full),
        .i_char_byte       (i_char_byte),
        .i_end_of_input    (i_end_of_input),
        .empty             (empty),
        .pop               (pop),
        .o_kind            (o_kind),
        .o_number_value    (o_number_value),
        .o_fraction_value  (o_fraction_value),
        .o_fraction_digits (o_fraction_digits),
        .o_token_offset    (o_token_offset),
        .o_token_length    (o_token_length),
        .o_last_of_step    (o_last_of_step)
    );

    // Output side: check accepted words, then choose next pop
    always @(posedge i_clk) begin
        t_word got;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                got.last       = o_last_of_step;
                got.tok.kind   = o_kind;
                got.tok.num    = o_number_value;
                got.tok.frac   = o_fraction_value;
                got.tok.digits = o_fraction_digits;
                got.tok.offset = o_token_offset;
                got.tok.length = o_token_length;
                sb.check_word(got);
            end
            // long hold so the block backs up into its input
            if (pressure_armed && !pressure_taken) begin
                pressure_taken = 1'b1;
                hold_left      = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= !(rx_stall_pct > 0 && $urandom_range(99) < rx_stall_pct);
            end
        end
    end

    // Watchdog: too long without any word moving on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((push && !full) || (pop && !empty)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no word moved for %0d cycles, %0d words pending",
                         quiet_cycles, sb.expected_q.size());
                $display("[assembly_line_tokenizer] ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Source byte drivers
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] c, input logic eoi);
        while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push           <= 1'b1;
        i_char_byte    <= c;
        i_end_of_input <= eoi;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sb.note_byte(c, eoi);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
    endtask

    function automatic logic [7:0] rand_digit();
        return 8'($urandom_range(8'h30, 8'h39));
    endfunction

    function automatic logic [7:0] rand_alpha();
        return $urandom_range(1) ? 8'($urandom_range(8'h61, 8'h7A))
                                 : 8'($urandom_range(8'h41, 8'h5A));
    endfunction

    task automatic send_ident(input int n);
        int r;
        send_byte($urandom_range(9) == 0 ? 8'h5F : rand_alpha(), 1'b0);
        for (int i = 1; i < n; i++) begin
            r = $urandom_range(9);
            send_byte(r < 6 ? rand_alpha() : (r < 9 ? rand_digit() : 8'h5F), 1'b0);
        end
    endtask

    task automatic send_punct(input int n);
        logic [7:0] c;
        for (int i = 0; i < n; i++) begin
            do c = 8'($urandom_range(8'h21, 8'h7E));
            while (!token_scoreboard::is_punct(c));
            send_byte(c, 1'b0);
        end
    endtask

    task automatic send_digits(input int n);
        for (int i = 0; i < n; i++) send_byte(rand_digit(), 1'b0);
    endtask

    task automatic send_real(input int n_int, input int n_frac);
        send_digits(n_int);
        send_byte(".", 1'b0);
        send_digits(n_frac);
    endtask

    // lowercase hex digits, now and then an uppercase or out-of-range letter
    task automatic send_hex(input int n);
        int r;
        send_text("0x");
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(19);
            if (r == 0) send_byte(8'($urandom_range(8'h41, 8'h46)), 1'b0);
            else if (r == 1) send_byte(8'($urandom_range(8'h67, 8'h7A)), 1'b0);
            else if (r < 10) send_byte(rand_digit(), 1'b0);
            else send_byte(8'($urandom_range(8'h61, 8'h66)), 1'b0);
        end
    endtask

    // a byte the scanner does not know: kills the rest of the line
    task automatic send_unknown();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 254));
        while (c == CH_LF || c == CH_SPACE || c == CH_TAB || c == "_" ||
               token_scoreboard::is_alpha(c) || token_scoreboard::is_digit(c) ||
               token_scoreboard::is_punct(c));
        send_byte(c, 1'b0);
    endtask

    task automatic send_gap();
        int r;
        r = $urandom_range(99);
        if (r < 15) return;
        send_byte(r < 70 ? CH_SPACE : CH_TAB, 1'b0);
        if (r >= 90) send_byte(CH_SPACE, 1'b0);
    endtask

    // one random source line ending in a newline
    task automatic send_line();
        int n_tok;
        int r;
        n_tok = $urandom_range(6);
        for (int t = 0; t < n_tok; t++) begin
            r = $urandom_range(99);
            if (r < 25) send_ident($urandom_range(1, 8));
            else if (r < 45) send_punct($urandom_range(1, 4));
            else if (r < 65) send_digits($urandom_range(4) == 0 ? $urandom_range(18, 24)
                                                                 : $urandom_range(1, 5));
            else if (r < 80) send_real($urandom_range(1, 4),
                                       $urandom_range(4) == 0 ? $urandom_range(18, 24)
                                                              : $urandom_range(4));
            else if (r < 95) send_hex($urandom_range(4) == 0 ? $urandom_range(16, 20)
                                                             : $urandom_range(6));
            else send_unknown();
            send_gap();
        end
        send_byte(CH_LF, 1'b0);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int phase_start;
        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed line: every kind, empty hex, bare real, tab, dead tail, empty line
        send_text("_aZ9 0x0f 0x 1. 2.5");
        send_byte(CH_TAB, 1'b0);
        send_text("~!;09 1.2.3 0xAg");
        send_byte(CH_DEL, 1'b0);
        send_text("#A");
        send_byte(CH_LF, 1'b0);
        send_byte(CH_LF, 1'b0);

        // random lines: calm, sender idle, receiver stalling, both, output hold
        for (int ph = 0; ph < 5; ph++) begin
            tx_idle_pct  = (ph == 1) ? 67 : (ph == 3 ? 11 : 0);
            rx_stall_pct = (ph == 2) ? 67 : (ph == 3 ? 11 : 0);
            if (ph == 4) pressure_armed = 1'b1;
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES) send_line();
        end

        // leave a partial line now and then, then close the stream
        if ($urandom_range(1)) send_digits(3);
        case ($urandom_range(3))
            0: send_byte(CH_NUL, 1'b0);
            1: send_byte(CH_EOF, 1'b0);
            2: send_byte(CH_LF, 1'b1);
            default: send_byte(rand_alpha(), 1'b1);
        endcase
        // everything after the end must be ignored
        for (int i = 0; i < 8; i++)
            send_byte(8'($urandom_range(255)), i == 0 ? 1'b1 : 1'($urandom_range(1)));
        push <= 1'b0;

        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("source bytes sent: %0d, token words checked: %0d",
                 bytes_sent, sb.words_seen);
        $display("ident %0d punct %0d dec %0d real %0d hex %0d line %0d",
                 sb.kind_count[K_IDENT], sb.kind_count[K_PUNCT], sb.kind_count[K_DEC],
                 sb.kind_count[K_REAL], sb.kind_count[K_HEX], sb.kind_count[K_LINE]);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("[assembly_line_tokenizer] OK");
        end else begin
            $display("[assembly_line_tokenizer] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
